>>> rtl/pgm_binary_header_parser_macros.svh
// assertion macros for the pgm header parser
`ifndef PGM_BINARY_HEADER_PARSER_MACROS_SVH
`define PGM_BINARY_HEADER_PARSER_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define PGMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked through reset as well
`define PGMP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PGMP_ASSERT(lbl, prop, msg)
`define PGMP_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> rtl/pgmp_pkg.sv
`default_nettype none
package pgmp_pkg;

  // dimension limit in bits and the resulting largest dimension
  localparam int DIM_BITS = 16;
  localparam logic [16:0] DIM_LIM = 17'((1 << DIM_BITS) - 1);

  // decimal field saturation value
  localparam logic [16:0] FIELD_SAT = 17'h1FFFF;
  localparam logic [16:0] FIELD_MAX16 = 17'h0FFFF;

  // character codes
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_REQUIRED_MAXVAL = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_DIMENSION   = 1'd1;

  localparam logic [15:0] REQUIRED_MAXVAL_INIT = 16'd255;
  localparam logic [15:0] MAX_DIMENSION_INIT   = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_MAGIC0 = 3'd0,
    PH_MAGIC1 = 3'd1,
    PH_WIDTH  = 3'd2,
    PH_HEIGHT = 3'd3,
    PH_MAXVAL = 3'd4,
    PH_PIXELS = 3'd5,
    PH_SINK   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MAGIC    = 3'd1,
    ST_HEADER   = 3'd2,
    ST_MAXVAL   = 3'd3,
    ST_DIM      = 3'd4,
    ST_SHORT    = 3'd5,
    ST_TRAILING = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } pgmp_in_t;

  typedef struct packed {
    logic [7:0]  pixel;
    logic        pixel_valid;
    logic        final_res;
    status_t     status;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } pgmp_out_t;

  // per-file parser state
  typedef struct packed {
    phase_t      phase;
    logic        in_comment;
    logic [16:0] field_value;
    logic        digits_seen;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [31:0] pixels_left;
    status_t     error_code;
  } pgmp_state_t;

  localparam pgmp_state_t STATE_INIT = '{
    phase:       PH_MAGIC0,
    in_comment:  1'b0,
    field_value: 17'd0,
    digits_seen: 1'b0,
    width_reg:   16'd0,
    height_reg:  16'd0,
    pixels_left: 32'd0,
    error_code:  ST_OK
  };

endpackage
`default_nettype wire

>>> rtl/pgmp_step.sv
`default_nettype none
// next-state and result logic for one file byte
module pgmp_step import pgmp_pkg::*; (
  input  var pgmp_state_t st,
  input  var pgmp_in_t    item,
  input  wire [15:0]      required_maxval,
  input  wire [15:0]      max_dimension,
  output pgmp_state_t     st_next,
  output pgmp_out_t       res_gen,
  output logic            res_gen_valid
);

  // error entry: first error wins, header size dropped if not yet accepted
  function automatic pgmp_state_t fail_st(input pgmp_state_t s, input status_t code);
    pgmp_state_t r;
    r = s;
    if (s.error_code == ST_OK) r.error_code = code;
    if (s.phase < PH_PIXELS) begin
      r.width_reg  = '0;
      r.height_reg = '0;
    end
    r.phase       = PH_SINK;
    r.in_comment  = 1'b0;
    r.digits_seen = 1'b0;
    r.field_value = '0;
    return r;
  endfunction

  function automatic logic dim_ok(input logic [15:0] d, input logic [15:0] lim);
    return (d != 16'd0) && (d <= lim) && ({1'b0, d} <= DIM_LIM);
  endfunction

  logic [7:0]  c;
  logic        is_digit;
  logic        is_space;
  logic [3:0]  digit;
  logic [20:0] acc;
  logic [16:0] acc_sat;
  logic [15:0] dim_val;
  logic [31:0] area;

  // byte classes and the decimal accumulate
  assign c        = item.data_byte;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign digit    = 4'(c - CH_ZERO);
  assign acc      = ({4'd0, st.field_value} << 3) + ({4'd0, st.field_value} << 1)
                    + {17'd0, digit};
  assign acc_sat  = (acc > {4'd0, FIELD_SAT}) ? FIELD_SAT : acc[16:0];
  assign dim_val  = (st.field_value > FIELD_MAX16) ? 16'd0 : st.field_value[15:0];
  assign area     = {16'd0, st.width_reg} * {16'd0, st.height_reg};

  always_comb begin
    pgmp_state_t ns;
    logic        emit;
    logic        hdone;
    ns    = st;
    emit  = 1'b0;
    hdone = 1'b0;

    unique case (st.phase)
      PH_MAGIC0: begin
        if (c == CH_P) ns.phase = PH_MAGIC1;
        else ns = fail_st(ns, ST_MAGIC);
      end
      PH_MAGIC1: begin
        if (c == CH_5) ns.phase = PH_WIDTH;
        else ns = fail_st(ns, ST_MAGIC);
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
        if (st.in_comment) begin
          if (c == CH_LF) ns.in_comment = 1'b0;
        end else begin
          // a digit run ends or continues
          if (st.digits_seen) begin
            if (is_digit) begin
              ns.field_value = acc_sat;
              hdone = 1'b1;
            end else if (st.phase == PH_MAXVAL) begin
              hdone = 1'b1;
              if (!is_space) begin
                ns = fail_st(ns, ST_HEADER);
              end else if ({1'b0, required_maxval} != st.field_value) begin
                ns = fail_st(ns, ST_MAXVAL);
              end else if (!dim_ok(st.width_reg, max_dimension) ||
                           !dim_ok(st.height_reg, max_dimension)) begin
                ns = fail_st(ns, ST_DIM);
              end else begin
                ns.pixels_left = area;
                ns.phase       = PH_PIXELS;
                ns.digits_seen = 1'b0;
                ns.field_value = '0;
              end
            end else begin
              if (st.phase == PH_WIDTH) begin
                ns.width_reg = dim_val;
                ns.phase     = PH_HEIGHT;
              end else begin
                ns.height_reg = dim_val;
                ns.phase      = PH_MAXVAL;
              end
              ns.digits_seen = 1'b0;
              ns.field_value = '0;
            end
          end
          // separators, comment start, first digit
          if (!hdone) begin
            if (is_space) begin
              ns.in_comment = ns.in_comment;
            end else if (c == CH_HASH) begin
              ns.in_comment = 1'b1;
            end else if (is_digit) begin
              ns.digits_seen = 1'b1;
              ns.field_value = {13'd0, digit};
            end else begin
              ns = fail_st(ns, ST_HEADER);
            end
          end
        end
      end
      PH_PIXELS: begin
        if (st.pixels_left != 32'd0) begin
          emit           = 1'b1;
          ns.pixels_left = st.pixels_left - 32'd1;
        end else begin
          ns = fail_st(ns, ST_TRAILING);
        end
      end
      PH_SINK: begin
        ns = st;
      end
      default: begin
        ns = st;
      end
    endcase

    // end of file checks
    if (item.last && (ns.error_code == ST_OK)) begin
      if (ns.phase <= PH_MAGIC1) ns = fail_st(ns, ST_MAGIC);
      else if (ns.phase < PH_PIXELS) ns = fail_st(ns, ST_HEADER);
      else if ((ns.phase == PH_PIXELS) && (ns.pixels_left != 32'd0))
        ns = fail_st(ns, ST_SHORT);
    end

    // result beat
    res_gen_valid        = emit || item.last;
    res_gen.pixel        = emit ? c : 8'd0;
    res_gen.pixel_valid  = emit;
    res_gen.final_res    = item.last;
    res_gen.status       = ns.error_code;
    res_gen.image_width  = ns.width_reg;
    res_gen.image_height = ns.height_reg;

    st_next = item.last ? STATE_INIT : ns;
  end

endmodule
`default_nettype wire

>>> rtl/pgm_binary_header_parser.sv
`default_nettype none
// channel | direction | handshake              | beat
// item    | in        | item_valid / item_stall | pgmp_in_t  (data_byte, last)
// res     | out       | res_valid / res_stall   | pgmp_out_t (pixel .. image_height)
// cfg     | in        | cfg_we                  | cfg_index, cfg_wdata
//
// one file byte is taken per cycle while item_stall is low; any result beat is registered
// the critical path is the header check with the 16x16 width*height product
// a two-entry result buffer (res plus one skid entry) lets bytes flow while res waits;
// item_stall rises only when both entries hold beats
// rst clears the file state and the buffer, and loads maxval 255 and dimension limit 65535
// a cfg write is in effect for the byte accepted in the next cycle
`include "pgm_binary_header_parser_macros.svh"
module pgm_binary_header_parser import pgmp_pkg::*; (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    item_valid,
  output logic                   item_stall,
  input  var pgmp_in_t           item,
  output logic                   res_valid,
  input  wire                    res_stall,
  output pgmp_out_t              res,
  input  wire                    cfg_we,
  input  wire [CFG_IDX_BITS-1:0] cfg_index,
  input  wire [15:0]             cfg_wdata
);

  logic [15:0] required_maxval;
  logic [15:0] max_dimension;
  pgmp_state_t st;
  pgmp_state_t st_next;
  pgmp_out_t   res_gen;
  logic        res_gen_valid;
  pgmp_out_t   skid;
  logic        skid_valid;
  logic        accept;
  logic        take;
  logic        push;

  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign take       = res_valid && !res_stall;
  assign push       = accept && res_gen_valid;

  pgmp_step u_step (
    .st            (st),
    .item          (item),
    .required_maxval(required_maxval),
    .max_dimension (max_dimension),
    .st_next       (st_next),
    .res_gen       (res_gen),
    .res_gen_valid (res_gen_valid)
  );

  // parser state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st              <= STATE_INIT;
      required_maxval <= REQUIRED_MAXVAL_INIT;
      max_dimension   <= MAX_DIMENSION_INIT;
    end else begin
      if (accept) st <= st_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_REQUIRED_MAXVAL: required_maxval <= cfg_wdata;
          REG_MAX_DIMENSION:   max_dimension   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // result buffer valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        res_valid <= push;
      end
    end else if (!res_valid) begin
      res_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (take && skid_valid) begin
      res <= skid;
    end else if (take || !res_valid) begin
      if (push) res <= res_gen;
    end else if (push) begin
      skid <= res_gen;
    end
  end

  `PGMP_ASSERT_RST(a_rst_empty, rst |=> !res_valid && !skid_valid, "result buffer not empty after reset")
  `PGMP_ASSERT(a_skid_order, skid_valid |-> res_valid, "skid entry held while res is empty")
  `PGMP_ASSERT(a_last_restart, accept && item.last |=> st.phase == PH_MAGIC0, "no restart after last byte")
  `PGMP_ASSERT(a_pixel_size, res_valid && res.pixel_valid |-> res.image_width != 16'd0 && res.image_height != 16'd0, "pixel beat without image size")

endmodule
`default_nettype wire

>>> test/pgm_binary_header_parser_tb.sv
`timescale 1ns / 100ps
module pgm_binary_header_parser_tb;
  import pgmp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOWN_MISMATCHES = 10;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    item_valid = 1'b0;
  logic                    item_stall;
  pgmp_in_t                item = '0;
  logic                    res_valid;
  logic                    res_stall = 1'b0;
  pgmp_out_t               res;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [15:0]             cfg_wdata = '0;

  pgm_binary_header_parser dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the parser state and registers
  pgmp_state_t file_st = STATE_INIT;
  logic [15:0] want_maxval = REQUIRED_MAXVAL_INIT;
  logic [15:0] dim_limit = MAX_DIMENSION_INIT;

  pgmp_out_t   awaited_res[$];
  logic [7:0]  file_bytes[$];

  int unsigned send_idle_pct = 10;
  int unsigned recv_stall_pct = 62;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned files_sent = 0;
  int unsigned bytes_sent = 0;
  int unsigned pixels_seen = 0;
  int unsigned finals_seen = 0;

  // character classes
  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // first error sticks, the rest of the file is dropped
  function automatic void set_error(status_t code);
    if (file_st.error_code == ST_OK) file_st.error_code = code;
    if (file_st.phase < PH_PIXELS) begin
      file_st.width_reg = '0;
      file_st.height_reg = '0;
    end
    file_st.phase = PH_SINK;
    file_st.in_comment = 1'b0;
    file_st.digits_seen = 1'b0;
    file_st.field_value = '0;
  endfunction

  function automatic bit size_fits(logic [15:0] d);
    return d != 16'd0 && d <= dim_limit && {1'b0, d} <= DIM_LIM;
  endfunction

  // maxval and dimension checks once the separator arrives
  function automatic void close_header();
    if (file_st.field_value != {1'b0, want_maxval}) begin
      set_error(ST_MAXVAL);
    end else if (!size_fits(file_st.width_reg) || !size_fits(file_st.height_reg)) begin
      set_error(ST_DIM);
    end else begin
      file_st.pixels_left = 32'(file_st.width_reg) * 32'(file_st.height_reg);
      file_st.phase = PH_PIXELS;
      file_st.digits_seen = 1'b0;
      file_st.field_value = '0;
    end
  endfunction

  // one byte of the width, height or maxval section
  function automatic void header_char(logic [7:0] c);
    int unsigned acc;
    logic [15:0] dim;
    if (file_st.in_comment) begin
      if (c == CH_LF) file_st.in_comment = 1'b0;
      return;
    end
    if (file_st.digits_seen) begin
      if (is_numeral(c)) begin
        acc = 32'(file_st.field_value) * 10 + 32'(c - CH_ZERO);
        file_st.field_value = (acc > 32'(FIELD_SAT)) ? FIELD_SAT : acc[16:0];
        return;
      end
      if (file_st.phase == PH_MAXVAL) begin
        if (is_blank(c)) close_header();
        else set_error(ST_HEADER);
        return;
      end
      // oversized width or height is kept as zero
      dim = (file_st.field_value > FIELD_MAX16) ? 16'd0 : file_st.field_value[15:0];
      if (file_st.phase == PH_WIDTH) file_st.width_reg = dim;
      else file_st.height_reg = dim;
      file_st.phase = phase_t'(file_st.phase + 1);
      file_st.digits_seen = 1'b0;
      file_st.field_value = '0;
    end
    if (is_blank(c)) return;
    if (c == CH_HASH) begin
      file_st.in_comment = 1'b1;
      return;
    end
    if (is_numeral(c)) begin
      file_st.digits_seen = 1'b1;
      file_st.field_value = 17'(c - CH_ZERO);
      return;
    end
    set_error(ST_HEADER);
  endfunction

  // advance the shadow parser by one byte; returns 1 if a result beat is due
  function automatic bit parse_byte(input pgmp_in_t b, output pgmp_out_t r);
    bit emit;
    logic [7:0] pix;
    emit = 1'b0;
    pix = 8'd0;
    case (file_st.phase)
      PH_MAGIC0: begin
        if (b.data_byte == CH_P) file_st.phase = PH_MAGIC1;
        else set_error(ST_MAGIC);
      end
      PH_MAGIC1: begin
        if (b.data_byte == CH_5) file_st.phase = PH_WIDTH;
        else set_error(ST_MAGIC);
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL: header_char(b.data_byte);
      PH_PIXELS: begin
        if (file_st.pixels_left > 0) begin
          emit = 1'b1;
          pix = b.data_byte;
          file_st.pixels_left = file_st.pixels_left - 1;
        end else begin
          set_error(ST_TRAILING);
        end
      end
      default: ;
    endcase
    // end of file decides the status if nothing failed yet
    if (b.last && file_st.error_code == ST_OK) begin
      if (file_st.phase <= PH_MAGIC1) set_error(ST_MAGIC);
      else if (file_st.phase < PH_PIXELS) set_error(ST_HEADER);
      else if (file_st.phase == PH_PIXELS && file_st.pixels_left > 0) set_error(ST_SHORT);
    end
    r.pixel = pix;
    r.pixel_valid = emit;
    r.final_res = b.last;
    r.status = file_st.error_code;
    r.image_width = file_st.width_reg;
    r.image_height = file_st.height_reg;
    if (b.last) file_st = STATE_INIT;
    return emit || b.last;
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES) $display("mismatch: %s", what);
  endtask

  // result checker
  always @(posedge clk) begin : check_res
    pgmp_out_t want;
    if (!rst && res_valid && !res_stall) begin
      if (res.pixel_valid) pixels_seen++;
      if (res.final_res) finals_seen++;
      if (awaited_res.size() == 0) begin
        note_mismatch($sformatf("unexpected beat pix=%0h pv=%0b fin=%0b st=%0d w=%0d h=%0d",
          res.pixel, res.pixel_valid, res.final_res, res.status,
          res.image_width, res.image_height));
      end else begin
        want = awaited_res.pop_front();
        if (res.pixel !== want.pixel || res.pixel_valid !== want.pixel_valid ||
            res.final_res !== want.final_res || res.status !== want.status ||
            res.image_width !== want.image_width ||
            res.image_height !== want.image_height) begin
          note_mismatch($sformatf({"want pix=%0h pv=%0b fin=%0b st=%0d w=%0d h=%0d, ",
            "got pix=%0h pv=%0b fin=%0b st=%0d w=%0d h=%0d"},
            want.pixel, want.pixel_valid, want.final_res, want.status,
            want.image_width, want.image_height,
            res.pixel, res.pixel_valid, res.final_res, res.status,
            res.image_width, res.image_height));
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) res_stall <= ($urandom_range(99) < recv_stall_pct);

  // run limit
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("end of test: mismatches");
    $finish;
  end

  // send one byte, wait for the handshake, record the expected beat
  task automatic send_byte(input logic [7:0] d, input bit fin);
    pgmp_out_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{data_byte: d, last: fin};
    do @(posedge clk); while (item_stall);
    if (parse_byte('{data_byte: d, last: fin}, r)) awaited_res.push_back(r);
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    file_bytes.delete();
    files_sent++;
  endtask

  // stop sending and let every expected beat arrive
  task automatic drain();
    item_valid <= 1'b0;
    while (awaited_res.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_REQUIRED_MAXVAL) want_maxval = v;
    else dim_limit = v;
  endtask

  // file assembly helpers
  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
  endtask

  task automatic put_num(input longint unsigned v);
    if ($urandom_range(19) == 0) file_bytes.push_back(CH_ZERO);
    put_text($sformatf("%0d", v));
  endtask

  // space or one of the control blanks tab through carriage return
  function automatic logic [7:0] blank_char();
    int unsigned r;
    r = $urandom_range(5);
    return (r == 0) ? CH_SPACE : 8'(CH_TAB + r - 1);
  endfunction

  // whitespace and comments between fields
  task automatic put_gap(input bit may_be_empty);
    int unsigned n;
    logic [7:0] c;
    n = $urandom_range(may_be_empty ? 0 : 1, 3);
    repeat (n) begin
      if ($urandom_range(9) == 0) begin
        file_bytes.push_back(CH_HASH);
        repeat ($urandom_range(4)) begin
          c = 8'($urandom_range(255));
          file_bytes.push_back(c == CH_LF ? CH_HASH : c);
        end
        file_bytes.push_back(CH_LF);
      end else begin
        file_bytes.push_back(blank_char());
      end
    end
  endtask

  function automatic longint unsigned pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 6);
    if (r < 85) return 0;
    if (r < 90) return dim_limit;
    if (r < 95) return longint'(dim_limit) + 1;
    case ($urandom_range(2))
      0: return 65536;
      1: return 999999;
      default: return 65535;
    endcase
  endfunction

  function automatic longint unsigned pick_maxval();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return want_maxval;
    if (r < 90) return 0;
    return $urandom_range(70000);
  endfunction

  // header plus pixels, mostly well formed, with some pixel counts short or long
  task automatic build_image_file();
    longint unsigned w, h, area;
    int unsigned r, npix;
    file_bytes.delete();
    put_text("P5");
    put_gap(1);
    w = pick_size();
    put_num(w);
    put_gap(0);
    h = pick_size();
    put_num(h);
    put_gap(0);
    put_num(pick_maxval());
    // the separator after maxval, sometimes doubled or replaced by '#' or a random byte
    r = $urandom_range(99);
    if (r < 88) begin
      file_bytes.push_back(blank_char());
    end else if (r < 92) begin
      file_bytes.push_back(CH_HASH);
    end else if (r < 96) begin
      file_bytes.push_back(8'($urandom_range(255)));
    end else begin
      file_bytes.push_back(blank_char());
      file_bytes.push_back(blank_char());
    end
    area = w * h;
    if (area > 64) begin
      npix = $urandom_range(4);
    end else begin
      r = $urandom_range(99);
      if (r < 85) npix = 32'(area);
      else if (r < 92) npix = (area > 0) ? 32'(area - 1) : 32'd0;
      else npix = 32'(area) + $urandom_range(1, 3);
    end
    repeat (npix) file_bytes.push_back(8'($urandom_range(255)));
  endtask

  // keep, corrupt, truncate or replace a built file
  task automatic damage_file();
    int unsigned r, n;
    r = $urandom_range(99);
    if (r < 70) begin
      return;
    end else if (r < 80) begin
      file_bytes[$urandom_range(file_bytes.size() - 1)] = 8'($urandom_range(255));
    end else if (r < 90) begin
      n = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > n) void'(file_bytes.pop_back());
    end else begin
      file_bytes.delete();
      if ($urandom_range(1)) file_bytes.push_back(CH_P);
      if ($urandom_range(1)) file_bytes.push_back(CH_5);
      repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic send_random_files(input int unsigned byte_goal);
    int unsigned stop_at;
    stop_at = bytes_sent + byte_goal;
    while (bytes_sent < stop_at) begin
      build_image_file();
      damage_file();
      send_file();
    end
  endtask

  // clean files under reset settings
  task automatic test_well_formed();
    put_text("P5 2 2 255\n");
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'hA5);
    file_bytes.push_back(8'h5A);
    send_file();
    put_text("P5\n# comment 1\n#\n3\t1\r\n255 abc");
    send_file();
    put_text("P51 1 255\nQ");
    send_file();
  endtask

  // magic check and files that stop inside the magic
  task automatic test_magic_errors();
    put_text("X");
    send_file();
    put_text("P");
    send_file();
    put_text("P6 1 1 255\nz");
    send_file();
    put_text("Q5 1 1 255\nz");
    send_file();
  endtask

  // syntax problems and early ends inside the header
  task automatic test_header_errors();
    put_text("P5 2 x 255\nab");
    send_file();
    put_text("P5 1 1 255#");
    send_file();
    put_text("P5 1 1 255");
    send_file();
    put_text("P5 1 1");
    send_file();
    put_text("P5 1 1 25A\n");
    send_file();
  endtask

  // saturation, dimension limit and maxval register extremes
  task automatic test_field_limits();
    put_text("P5 999999 1 255\nz");
    send_file();
    put_text("P5 1 65536 255\nz");
    send_file();
    put_text("P5 1 1 254\nz");
    send_file();
    set_reg(REG_MAX_DIMENSION, 16'd3);
    put_text("P5 3 3 255\n123456789");
    send_file();
    put_text("P5 4 1 255\nabcd");
    send_file();
    set_reg(REG_MAX_DIMENSION, 16'd0);
    put_text("P5 1 1 255\nz");
    send_file();
    set_reg(REG_MAX_DIMENSION, 16'd1);
    set_reg(REG_REQUIRED_MAXVAL, 16'd0);
    put_text("P5 1 1 0\nz");
    send_file();
    set_reg(REG_REQUIRED_MAXVAL, 16'd1);
    put_text("P5 1 1 1 z");
    send_file();
    set_reg(REG_MAX_DIMENSION, 16'hFFFF);
    set_reg(REG_REQUIRED_MAXVAL, 16'hFFFF);
    put_text("P5 1 2 65535\nzz");
    send_file();
    // largest dimensions, ended after a couple of pixels
    set_reg(REG_REQUIRED_MAXVAL, REQUIRED_MAXVAL_INIT);
    put_text("P5 65535 65535 255\nab");
    send_file();
  endtask

  // pixel count: short, trailing, and bytes ignored after an error
  task automatic test_pixel_count();
    put_text("P5 2 2 255\nabc");
    send_file();
    put_text("P5 2 2 255\nabcde");
    send_file();
    put_text("P5 x P5 1 1 255\nq");
    send_file();
    put_text("P5 1 1 255\nq");
    send_file();
  endtask

  // random files under each idle pattern and a range of register settings
  task automatic test_random_files();
    int unsigned send_pct[3] = '{10, 62, 0};
    int unsigned recv_pct[3] = '{62, 10, 0};
    logic [15:0] mv, dl;
    for (int s = 0; s < 3; s++) begin
      send_idle_pct = send_pct[s];
      recv_stall_pct = recv_pct[s];
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(4))
          0: mv = 16'd255;
          1: mv = 16'd1;
          2: mv = 16'hFFFF;
          3: mv = 16'd0;
          default: mv = 16'($urandom_range(65535));
        endcase
        case ($urandom_range(5))
          0, 1: dl = 16'hFFFF;
          2, 3: dl = 16'($urandom_range(1, 8));
          4: dl = 16'd1;
          default: dl = 16'd0;
        endcase
        set_reg(REG_REQUIRED_MAXVAL, mv);
        set_reg(REG_MAX_DIMENSION, dl);
        send_random_files(110);
      end
    end
  endtask

  // sequence
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_well_formed();
    test_magic_errors();
    test_header_errors();
    test_field_limits();
    test_pixel_count();
    test_random_files();
    drain();
    repeat (8) @(posedge clk);
    if (awaited_res.size() != 0) note_mismatch($sformatf("%0d beats never arrived",
      awaited_res.size()));
    $display("sent %0d files (%0d bytes) under several register settings and idle patterns",
      files_sent, bytes_sent);
    $display("checked %0d pixel beats and %0d end-of-file beats, %0d mismatches",
      pixels_seen, finals_seen, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
